// ----- rtl/mexp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the modular exponentiation unit: request and result item types.
// No dependencies; used by the top level and its port list.
package mexp_pkg;

	// Width of every request field and of the result value (bad_modulus is a single bit)
	localparam int FIELD_W = 32;

	typedef struct packed {
		logic [FIELD_W-1:0] base_value;
		logic [FIELD_W-1:0] exponent;
		logic [FIELD_W-1:0] modulus;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] power_result;
		logic               bad_modulus;
	} out_item_t;

endpackage

// ----- rtl/mexp_rem.sv -----
`timescale 1ns / 1ps
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on nothing; instantiated by modular_exponentiation_unit.
module mexp_rem #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] remainder
);

	localparam int CNT_W = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] num_q;
	logic [WIDTH-1:0] div_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   next_rem;

	// Shift in the next dividend bit and subtract the divisor when it fits
	always_comb begin
		trial    = {rem_q, num_q[WIDTH-1]};
		next_rem = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;
	end

	// Step through all dividend bits, MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			num_q  <= '0;
			div_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(WIDTH - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				num_q  <= dividend;
				div_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= next_rem[WIDTH-1:0];
				num_q <= {num_q[WIDTH-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WIDTH - 1))
					busy_q <= 1'b0;
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

`ifndef NO_ASSERTIONS
	// A new division never starts over one in flight
	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("mexp_rem: start while busy");
	// The partial remainder stays below the divisor
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start |=> (rem_q < div_q) || (div_q == '0))
		else $error("mexp_rem: partial remainder out of range");
	// Done follows only the last step
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("mexp_rem: done while still busy");
`endif

endmodule

// ----- rtl/mexp_mulmod.sv -----
`timescale 1ns / 1ps
// Bit-serial modular multiplier: a*b mod m by shift-and-add, one bit of b per cycle.
// Depends on nothing; instantiated by modular_exponentiation_unit.
module mexp_mulmod #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	input  logic [WIDTH-1:0] m,
	output logic             done,
	output logic [WIDTH-1:0] product
);

	localparam int CNT_W = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] m_q;
	logic [WIDTH-1:0] acc_next;
	logic [WIDTH-1:0] dbl_next;

	// (x + y) mod m for x, y < m
	function automatic logic [WIDTH-1:0] add_mod(
		input logic [WIDTH-1:0] x,
		input logic [WIDTH-1:0] y,
		input logic [WIDTH-1:0] md
	);
		logic [WIDTH:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, md})
			s = s - {1'b0, md};
		return s[WIDTH-1:0];
	endfunction

	// Accumulate the current addend when the multiplier bit is set, then double it
	always_comb begin
		acc_next = b_q[0] ? add_mod(acc_q, a_q, m_q) : acc_q;
		dbl_next = add_mod(a_q, a_q, m_q);
	end

	// Walk all WIDTH multiplier bits, LSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			m_q    <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(WIDTH - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				acc_q  <= '0;
				a_q    <= a;
				b_q    <= b;
				m_q    <= m;
			end else if (busy_q) begin
				acc_q <= acc_next;
				a_q   <= dbl_next;
				b_q   <= {1'b0, b_q[WIDTH-1:1]};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WIDTH - 1))
					busy_q <= 1'b0;
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

`ifndef NO_ASSERTIONS
	// A new product never starts over one in flight
	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("mexp_mulmod: start while busy");
	// Accumulator and addend stay reduced while stepping
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !start |-> (acc_q < m_q) && (a_q < m_q))
		else $error("mexp_mulmod: operand out of range");
	// Done is a single-cycle pulse
	assert property (@(posedge clk) disable iff (!arst_n) done_q |=> !done_q)
		else $error("mexp_mulmod: done held");
`endif

endmodule

// ----- rtl/modular_exponentiation_unit.sv -----
`timescale 1ns / 1ps
// Each request reduces the base, then scans the exponent bits; a clear exponent bit
// skips the multiply, and a zero modulus goes straight to the result.
// One request at a time, set by the single shared bit-serial modular multiplier
// and the bit-serial base reduction.
// A new request is taken while the last result waits in the output register.
// arst_n clears the controller and the output register; no result is pending after reset.
module modular_exponentiation_unit #(
	parameter int WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mexp_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output mexp_pkg::out_item_t out_item
);

	import mexp_pkg::*;

	localparam int CNT_W = $clog2(WIDTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_REDUCE,
		S_BIT,
		S_MUL,
		S_SQR,
		S_DONE
	} state_t;

	state_t           state_q;
	logic [WIDTH-1:0] base_q;
	logic [WIDTH-1:0] exp_q;
	logic [WIDTH-1:0] mod_q;
	logic [WIDTH-1:0] acc_q;
	logic             bad_q;
	logic [CNT_W-1:0] bit_cnt_q;
	logic             out_valid_q;
	out_item_t        out_item_q;

	logic             accept;
	logic [WIDTH-1:0] in_base;
	logic [WIDTH-1:0] in_mod;
	logic             rem_start;
	logic             rem_done;
	logic [WIDTH-1:0] rem_value;
	logic             mul_start;
	logic             mul_done;
	logic [WIDTH-1:0] mul_a;
	logic [WIDTH-1:0] mul_product;
	logic             out_free;

	// Take operands as their low WIDTH bits
	assign in_base  = WIDTH'(in_item.base_value);
	assign in_mod   = WIDTH'(in_item.modulus);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Reduce the base right away unless the modulus is zero
	assign rem_start = accept && (in_mod != '0);

	// Multiply on a set exponent bit, square on a clear one or after the multiply
	assign mul_start = (state_q == S_BIT) || ((state_q == S_MUL) && mul_done);
	assign mul_a     = ((state_q == S_BIT) && exp_q[0]) ? acc_q : base_q;

	mexp_rem #(
		.WIDTH(WIDTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (in_base),
		.divisor  (in_mod),
		.done     (rem_done),
		.remainder(rem_value)
	);

	mexp_mulmod #(
		.WIDTH(WIDTH)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (base_q),
		.m      (mod_q),
		.done   (mul_done),
		.product(mul_product)
	);

	// Sequence the exponent scan and hold the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= '0;
			exp_q       <= '0;
			mod_q       <= '0;
			acc_q       <= '0;
			bad_q       <= 1'b0;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			if ((state_q == S_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						exp_q     <= WIDTH'(in_item.exponent);
						mod_q     <= in_mod;
						bit_cnt_q <= '0;
						if (in_mod == '0) begin
							acc_q   <= '0;
							bad_q   <= 1'b1;
							state_q <= S_DONE;
						end else begin
							acc_q   <= (in_mod == WIDTH'(1)) ? '0 : WIDTH'(1);
							bad_q   <= 1'b0;
							state_q <= S_REDUCE;
						end
					end
				end
				S_REDUCE: begin
					if (rem_done) begin
						base_q  <= rem_value;
						state_q <= S_BIT;
					end
				end
				S_BIT: begin
					state_q <= exp_q[0] ? S_MUL : S_SQR;
				end
				S_MUL: begin
					if (mul_done) begin
						acc_q   <= mul_product;
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					if (mul_done) begin
						base_q    <= mul_product;
						exp_q     <= {1'b0, exp_q[WIDTH-1:1]};
						bit_cnt_q <= bit_cnt_q + 1'b1;
						if (bit_cnt_q == CNT_W'(WIDTH - 1))
							state_q <= S_DONE;
						else
							state_q <= S_BIT;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_item_q.power_result <= FIELD_W'(acc_q);
						out_item_q.bad_modulus  <= bad_q;
						state_q                 <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef NO_ASSERTIONS
	// Reduction only completes while the controller waits for it
	assert property (@(posedge clk) disable iff (!arst_n) rem_done |-> state_q == S_REDUCE)
		else $error("modular_exponentiation_unit: stray reduction done");
	// Products only complete while a multiply or square is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_MUL) || (state_q == S_SQR))
		else $error("modular_exponentiation_unit: stray product done");
	// A zero modulus goes straight to the result with the flag set
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_mod == '0) |=> (state_q == S_DONE) && bad_q && (acc_q == '0))
		else $error("modular_exponentiation_unit: zero modulus not flagged");
	// A pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && out_valid_q && !out_ready |=> state_q == S_DONE)
		else $error("modular_exponentiation_unit: result register overrun");
`endif

endmodule
